// File: hdl/bfba_pkg.sv
// Package with the sizes and command codes of the byte FIFO with burst admission.
package bfba_pkg;

  // Ring size in bytes and the derived pointer widths.
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int PTR_W  = IDX_W + 1;

  // Largest number of bytes that one get returns.
  localparam int MAX_GET = 64;
  localparam int GET_W   = $clog2(MAX_GET + 1);

  // Field widths of the request and result channels.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 11;

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_PUT_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET       = 2'd2;

  // Result kinds.
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

endpackage

// File: hdl/byte_fifo_block_admission.sv
// Byte FIFO with burst admission: one ring memory, pointers and a result register.
// A put_byte request gives no result; a put_begin result is registered and ready in the cycle after
// the request is taken. A get emits one byte per cycle while the result register is not stalled,
// with the request side stalled until the last byte; each byte passes through the registered read
// port of the ring memory and then through the result register.
// Reset clears the pointers, the open burst count and the result valid flag at once;
// the ring memory is not cleared, and only written entries are ever returned.
module byte_fifo_block_admission
  import bfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [LEN_W-1:0]  request_length,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic              kind,
  output logic [LEN_W-1:0]  count,
  output logic [BYTE_W-1:0] data_out,
  output logic              last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state;
  logic              state_next;
  logic [PTR_W-1:0]  write_pointer;
  logic [PTR_W-1:0]  read_pointer;
  logic [PTR_W-1:0]  read_pointer_next;
  logic [LEN_W-1:0]  burst_remaining;
  logic [GET_W-1:0]  get_remaining;
  logic [GET_W-1:0]  get_total;

  logic [BYTE_W-1:0] ring_store [DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic              req_take;
  logic              out_free;
  logic              emit_take;
  logic [PTR_W-1:0]  fill;
  logic [PTR_W-1:0]  room;
  logic              room_ok;
  logic [GET_W-1:0]  get_capped;
  logic [GET_W-1:0]  get_n;
  logic              put_write;

  // Handshake: the result register is free when empty or being taken.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign req_take  = req_valid && !req_stall;
  assign emit_take = (state == ST_EMIT) && out_free;

  // Fill level and room from the free-running pointers.
  assign fill    = write_pointer - read_pointer;
  assign room    = PTR_W'(DEPTH) - fill;
  assign room_ok = (fill != PTR_W'(DEPTH)) && ({1'b0, room} >= {1'b0, request_length});

  // Get length saturated at the cap and then at the fill level.
  assign get_capped = (request_length > LEN_W'(MAX_GET)) ? GET_W'(MAX_GET)
                                                          : GET_W'(request_length);
  always_comb begin
    if (PTR_W'(get_capped) > fill) begin
      get_n = GET_W'(fill);
    end else begin
      get_n = get_capped;
    end
  end

  // A put_byte is stored only inside an open burst and with room left.
  assign put_write = req_take && (cmd == CMD_PUT_BYTE) &&
                     (burst_remaining != '0) && (fill != PTR_W'(DEPTH));

  // The read port always looks at the entry the read pointer will hold next.
  assign read_pointer_next = emit_take ? (read_pointer + PTR_W'(1)) : read_pointer;

  // Sequencer between idle and byte emission.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take && (cmd == CMD_GET) && (get_n != '0)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_take && (get_remaining == GET_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (put_write) begin
      ring_store[write_pointer[IDX_W-1:0]] <= data_byte;
    end
    rd_data <= ring_store[read_pointer_next[IDX_W-1:0]];
  end

  // Control state: pointers, burst count and get counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_pointer   <= '0;
      read_pointer    <= '0;
      burst_remaining <= '0;
      get_remaining   <= '0;
      get_total       <= '0;
    end else begin
      state        <= state_next;
      read_pointer <= read_pointer_next;
      if (req_take && (cmd == CMD_PUT_BEGIN)) begin
        burst_remaining <= room_ok ? request_length : '0;
      end else if (put_write) begin
        burst_remaining <= burst_remaining - LEN_W'(1);
      end
      if (put_write) begin
        write_pointer <= write_pointer + PTR_W'(1);
      end
      if (req_take && (cmd == CMD_GET)) begin
        get_remaining <= get_n;
        get_total     <= get_n;
      end else if (emit_take) begin
        get_remaining <= get_remaining - GET_W'(1);
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_take) begin
      rsp_valid <= 1'b1;
    end else if (req_take && (cmd == CMD_PUT_BEGIN)) begin
      rsp_valid <= 1'b1;
    end else if (req_take && (cmd == CMD_GET) && (get_n == '0)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (emit_take) begin
      kind     <= KIND_GET;
      count    <= LEN_W'(get_total);
      data_out <= rd_data;
      last     <= (get_remaining == GET_W'(1));
    end else if (req_take && (cmd == CMD_PUT_BEGIN)) begin
      kind     <= KIND_PUT;
      count    <= room_ok ? request_length : '0;
      data_out <= '0;
      last     <= 1'b1;
    end else if (req_take && (cmd == CMD_GET) && (get_n == '0)) begin
      kind     <= KIND_GET;
      count    <= '0;
      data_out <= '0;
      last     <= 1'b1;
    end
  end

endmodule

// File: bench/byte_fifo_block_admission_test.sv
// Self-checking testbench for the byte FIFO with burst admission, directed table then random.
`timescale 1ns / 1ps

module byte_fifo_block_admission_test;
  import bfba_pkg::*;

  // The one command code that the block has no use for.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  count;
    logic [BYTE_W-1:0] data;
    logic              last;
  } answer_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              typed;
    answer_t           want;
  } stim_row_t;

  localparam answer_t NO_ANSWER = '0;

  // Directed requests. Rows with typed set carry an answer that is obvious at a glance;
  // the other rows are checked against the predictor.
  localparam int NUM_ROWS = 25;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Get from an empty FIFO.
    '{CMD_GET,       8'h00, 11'd5,    1'b1, '{KIND_GET, 11'd0,    8'h00, 1'b1}},
    // Byte with no burst open is dropped.
    '{CMD_PUT_BYTE,  8'hAA, 11'd0,    1'b0, NO_ANSWER},
    // Burst of zero length opens nothing.
    '{CMD_PUT_BEGIN, 8'h00, 11'd0,    1'b1, '{KIND_PUT, 11'd0,    8'h00, 1'b1}},
    '{CMD_PUT_BYTE,  8'h55, 11'd0,    1'b0, NO_ANSWER},
    // Bursts larger than the ring are refused.
    '{CMD_PUT_BEGIN, 8'h00, 11'd1025, 1'b1, '{KIND_PUT, 11'd0,    8'h00, 1'b1}},
    '{CMD_PUT_BEGIN, 8'hFF, 11'd2047, 1'b1, '{KIND_PUT, 11'd0,    8'h00, 1'b1}},
    // A granted burst of four, then one byte too many.
    '{CMD_PUT_BEGIN, 8'h00, 11'd4,    1'b1, '{KIND_PUT, 11'd4,    8'h00, 1'b1}},
    '{CMD_PUT_BYTE,  8'h00, 11'd0,    1'b0, NO_ANSWER},
    '{CMD_PUT_BYTE,  8'hFF, 11'd2047, 1'b0, NO_ANSWER},
    '{CMD_PUT_BYTE,  8'h5A, 11'd0,    1'b0, NO_ANSWER},
    '{CMD_PUT_BYTE,  8'hA5, 11'd0,    1'b0, NO_ANSWER},
    '{CMD_PUT_BYTE,  8'h11, 11'd0,    1'b0, NO_ANSWER},
    // Get of zero length with data present.
    '{CMD_GET,       8'h00, 11'd0,    1'b1, '{KIND_GET, 11'd0,    8'h00, 1'b1}},
    '{CMD_GET,       8'h00, 11'd2,    1'b0, NO_ANSWER},
    // Oversized get saturates, then is cut to the fill level.
    '{CMD_GET,       8'h00, 11'd2047, 1'b0, NO_ANSWER},
    // A new burst request cancels the rest of the open one.
    '{CMD_PUT_BEGIN, 8'h00, 11'd3,    1'b1, '{KIND_PUT, 11'd3,    8'h00, 1'b1}},
    '{CMD_PUT_BYTE,  8'h01, 11'd0,    1'b0, NO_ANSWER},
    '{CMD_PUT_BEGIN, 8'h00, 11'd2,    1'b1, '{KIND_PUT, 11'd2,    8'h00, 1'b1}},
    '{CMD_PUT_BYTE,  8'h02, 11'd0,    1'b0, NO_ANSWER},
    '{CMD_PUT_BYTE,  8'h03, 11'd0,    1'b0, NO_ANSWER},
    '{CMD_PUT_BYTE,  8'h04, 11'd0,    1'b0, NO_ANSWER},
    // The unused command changes nothing.
    '{CMD_UNUSED,    8'hFF, 11'd2047, 1'b0, NO_ANSWER},
    '{CMD_GET,       8'h00, 11'd64,   1'b0, NO_ANSWER},
    // A burst the size of the whole ring fits an empty FIFO.
    '{CMD_PUT_BEGIN, 8'h00, 11'd1024, 1'b1, '{KIND_PUT, 11'd1024, 8'h00, 1'b1}},
    '{CMD_GET,       8'h00, 11'd1,    1'b1, '{KIND_GET, 11'd0,    8'h00, 1'b1}}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [CMD_W-1:0]  cmd = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic [LEN_W-1:0]  request_length = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              kind;
  logic [LEN_W-1:0]  count;
  logic [BYTE_W-1:0] data_out;
  logic              last;

  // Predictor state: a copy of the ring, its pointers and the open burst count.
  logic [BYTE_W-1:0] ring_copy [DEPTH];
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr = '0;
  logic [LEN_W-1:0]  burst_left = '0;

  answer_t awaited_answers [$];
  int      fail_count = 0;
  int      useful_requests = 0;
  int      send_idle_pct = 0;
  int      rsp_stall_pct = 0;

  byte_fifo_block_admission DUT (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .request_length (request_length),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .kind           (kind),
    .count          (count),
    .data_out       (data_out),
    .last           (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [PTR_W-1:0] fifo_level();
    return wr_ptr - rd_ptr;
  endfunction

  // Applies one accepted request to the predictor and queues the answers it causes.
  function automatic void compute_answers(logic [CMD_W-1:0] op, logic [BYTE_W-1:0] b,
                                          logic [LEN_W-1:0] len);
    logic [PTR_W-1:0] fill;
    logic [PTR_W-1:0] room;
    int               n;
    int               i;
    fill = fifo_level();
    room = PTR_W'(DEPTH) - fill;
    case (op)
      CMD_PUT_BEGIN: begin
        burst_left = (fill != DEPTH && room >= len) ? len : '0;
        awaited_answers.push_back(answer_t'{KIND_PUT, burst_left, 8'h00, 1'b1});
        useful_requests++;
      end
      CMD_PUT_BYTE: begin
        if (burst_left != 0 && fill < DEPTH) begin
          ring_copy[wr_ptr[IDX_W-1:0]] = b;
          wr_ptr++;
          burst_left--;
          useful_requests++;
        end
      end
      CMD_GET: begin
        n = (len > MAX_GET) ? MAX_GET : int'(len);
        if (n > fill) n = int'(fill);
        if (n == 0) begin
          awaited_answers.push_back(answer_t'{KIND_GET, 11'd0, 8'h00, 1'b1});
        end else begin
          for (i = 0; i < n; i++) begin
            awaited_answers.push_back(answer_t'{KIND_GET, LEN_W'(n),
                                                ring_copy[rd_ptr[IDX_W-1:0]], i == n - 1});
            rd_ptr++;
          end
        end
        useful_requests++;
      end
      default: begin
      end
    endcase
  endfunction

  // Presents one request, with a random gap ahead of it, and waits until it is taken.
  task automatic send_request(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] b,
                              input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid      <= 1'b1;
    cmd            <= op;
    data_byte      <= b;
    request_length <= len;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    compute_answers(op, b, len);
  endtask

  // A burst request followed by its bytes; a broken burst sends anywhere from no bytes to two too many.
  task automatic send_burst(input int len, input bit broken);
    int sent;
    int k;
    sent = broken ? $urandom_range(len + 2) : len;
    send_request(CMD_PUT_BEGIN, BYTE_W'($urandom), LEN_W'(len));
    for (k = 0; k < sent; k++) begin
      send_request(CMD_PUT_BYTE, BYTE_W'($urandom), LEN_W'($urandom));
    end
  endtask

  // Mostly well-formed bursts and gets, with some noise mixed in.
  task automatic random_traffic(input int quota);
    int first;
    int pick;
    int len;
    first = useful_requests;
    while (useful_requests - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_GET) : $urandom_range(1, 12);
        send_burst(len, $urandom_range(9) == 0);
      end else if (pick < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 16);
        send_request(CMD_GET, BYTE_W'($urandom), LEN_W'(len));
      end else if (pick < 90) begin
        send_request(CMD_PUT_BEGIN, BYTE_W'($urandom), LEN_W'($urandom_range(2047)));
      end else if (pick < 95) begin
        send_request(CMD_PUT_BYTE, BYTE_W'($urandom), LEN_W'($urandom));
      end else begin
        send_request(CMD_UNUSED, BYTE_W'($urandom), LEN_W'($urandom));
      end
    end
  endtask

  // Checks each accepted result against the oldest expected answer and randomizes stall.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected result: kind %0d count %0d data_out %0h last %0d",
               kind, count, data_out, last);
        fail_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          fail_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          fail_count++;
        end
        if (data_out !== want.data) begin
          $error("data_out: expected %0h, got %0h", want.data, data_out);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // Main sequence: reset, directed table, then random phases with different idling and result stalls.
  initial begin
    int r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_ROWS; r++) begin
      send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].len);
      if (DIRECTED_ROWS[r].typed) awaited_answers[awaited_answers.size() - 1] =
          DIRECTED_ROWS[r].want;
    end

    random_traffic(30);

    send_idle_pct = 50;
    random_traffic(30);

    // Hold off new requests until every outstanding answer is back.
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited_answers.size() != 0);

    send_idle_pct = 0;
    rsp_stall_pct = 50;
    random_traffic(30);

    send_idle_pct = 22;
    rsp_stall_pct = 22;
    random_traffic(30);

    req_valid <= 1'b0;
    do @(posedge clk); while (awaited_answers.size() != 0);
    repeat (2 * MAX_GET + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("byte_fifo_block_admission_test passed");
    end else begin
      $display("byte_fifo_block_admission_test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("byte_fifo_block_admission_test failed");
    $finish;
  end

endmodule
